FILE: design/morse_code_keyer_unit_defines.svh
// Assertion macros for the Morse keyer unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MORSE_CODE_KEYER_UNIT_DEFINES_SVH
`define MORSE_CODE_KEYER_UNIT_DEFINES_SVH

// Check a plain condition on every clock edge outside reset.
`define MCK_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MCK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/mck_pkg.sv
// Shared types, constants, Morse table and microcode ROM for the keyer.
// No dependencies; used by morse_code_keyer_unit.
package mck_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned DurW  = 18;
  localparam int unsigned CharW = 8;

  localparam logic [UnitW-1:0] UNIT_RESET = 16'd150;

  localparam logic [CharW-1:0] CHAR_A     = 8'h61;
  localparam logic [CharW-1:0] CHAR_Z     = 8'h7a;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_SYM,
    STEP_SEP,
    STEP_SPACE,
    STEP_GAP
  } step_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_LAST_SYM
  } cond_e;

  // One control word per microcode step.
  typedef struct packed {
    logic  emit;      // step produces a segment
    logic  lit;       // LED lit during the segment
    logic  use_dash;  // length comes from the current symbol
    logic  triple;    // three units when use_dash is clear
    logic  last;      // final segment of the character
    cond_e cond;
    step_e nxt;
    step_e jmp;       // taken when the condition holds
  } ctrl_t;

  // High nibble: symbol count; low nibble: symbols, first in the highest used bit.
  function automatic logic [7:0] morse_code(input logic [4:0] idx);
    logic [7:0] code;
    unique case (idx)
      5'd0:  code = 8'h21;
      5'd1:  code = 8'h48;
      5'd2:  code = 8'h4A;
      5'd3:  code = 8'h34;
      5'd4:  code = 8'h10;
      5'd5:  code = 8'h42;
      5'd6:  code = 8'h36;
      5'd7:  code = 8'h40;
      5'd8:  code = 8'h20;
      5'd9:  code = 8'h47;
      5'd10: code = 8'h35;
      5'd11: code = 8'h44;
      5'd12: code = 8'h23;
      5'd13: code = 8'h22;
      5'd14: code = 8'h37;
      5'd15: code = 8'h46;
      5'd16: code = 8'h4D;
      5'd17: code = 8'h32;
      5'd18: code = 8'h30;
      5'd19: code = 8'h11;
      5'd20: code = 8'h31;
      5'd21: code = 8'h41;
      5'd22: code = 8'h33;
      5'd23: code = 8'h49;
      5'd24: code = 8'h4B;
      5'd25: code = 8'h4C;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Microcode ROM.
  function automatic ctrl_t ucode(input step_e step);
    ctrl_t w;
    unique case (step)
      STEP_IDLE:  w = '{emit: 1'b0, lit: 1'b0, use_dash: 1'b0, triple: 1'b0, last: 1'b0,
                        cond: COND_DISPATCH, nxt: STEP_SYM, jmp: STEP_SPACE};
      STEP_SYM:   w = '{emit: 1'b1, lit: 1'b1, use_dash: 1'b1, triple: 1'b0, last: 1'b0,
                        cond: COND_LAST_SYM, nxt: STEP_SEP, jmp: STEP_GAP};
      STEP_SEP:   w = '{emit: 1'b1, lit: 1'b0, use_dash: 1'b0, triple: 1'b0, last: 1'b0,
                        cond: COND_ALWAYS, nxt: STEP_SYM, jmp: STEP_SYM};
      STEP_SPACE: w = '{emit: 1'b1, lit: 1'b0, use_dash: 1'b0, triple: 1'b0, last: 1'b0,
                        cond: COND_ALWAYS, nxt: STEP_GAP, jmp: STEP_GAP};
      STEP_GAP:   w = '{emit: 1'b1, lit: 1'b0, use_dash: 1'b0, triple: 1'b1, last: 1'b1,
                        cond: COND_ALWAYS, nxt: STEP_IDLE, jmp: STEP_IDLE};
      default:    w = '{emit: 1'b0, lit: 1'b0, use_dash: 1'b0, triple: 1'b0, last: 1'b0,
                        cond: COND_ALWAYS, nxt: STEP_IDLE, jmp: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/morse_code_keyer_unit.sv
// Morse keyer: one character in, a run of timed LED segments out.
// The first segment is registered: the dispatch step that takes the character
// moves to the first segment step, which loads the output register. A character
// with n segments takes one dispatch step plus one microcode step per segment
// in the single-step sequencer; no new character is taken before the final gap.
// Output stalls hold it. Reset clears it and output valid and sets unit_ticks to 150.
`include "morse_code_keyer_unit_defines.svh"

module morse_code_keyer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: unit_ticks
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] led_on, [18:1] duration_ticks, [23:19] zero
  output logic        m_axis_tlast    // last
);

  logic [mck_pkg::UnitW-1:0] unit_q;
  mck_pkg::step_e            step_q, step_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [3:0]                pat_q, pat_d;
  logic                      valid_q, valid_d;
  logic                      lit_q, lit_d;
  logic                      last_q, last_d;
  logic [mck_pkg::DurW-1:0]  dur_q, dur_d;

  mck_pkg::ctrl_t            ctrl;
  logic                      in_acc;
  logic                      out_free;
  logic                      emit_go;
  logic                      is_letter;
  logic [7:0]                code;
  logic [7:0]                char_off;
  logic [2:0]                code_len;
  logic [mck_pkg::DurW-1:0]  dur_one;
  logic [mck_pkg::DurW-1:0]  dur_three;
  logic                      long_seg;

  assign ctrl     = mck_pkg::ucode(step_q);
  assign out_free = !valid_q || m_axis_tready;
  assign emit_go  = ctrl.emit && out_free;

  assign s_axis_tready = (ctrl.cond == mck_pkg::COND_DISPATCH);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_letter = (s_axis_tdata >= mck_pkg::CHAR_A) && (s_axis_tdata <= mck_pkg::CHAR_Z);
  assign char_off  = s_axis_tdata - mck_pkg::CHAR_A;
  assign code      = mck_pkg::morse_code(char_off[4:0]);
  assign code_len  = code[6:4];

  // zero unit length counts as one tick
  assign dur_one   = (unit_q == '0) ? mck_pkg::DurW'(1) : mck_pkg::DurW'(unit_q);
  assign dur_three = dur_one + {dur_one[mck_pkg::DurW-2:0], 1'b0};
  assign long_seg  = ctrl.use_dash ? pat_q[3] : ctrl.triple;

  always_comb begin
    step_d  = step_q;
    cnt_d   = cnt_q;
    pat_d   = pat_q;
    valid_d = valid_q;
    lit_d   = lit_q;
    last_d  = last_q;
    dur_d   = dur_q;

    unique case (ctrl.cond)
      mck_pkg::COND_DISPATCH: begin
        if (in_acc) begin
          // left-align the pattern so the first symbol sits in bit 3
          cnt_d = code_len;
          pat_d = 4'(code[3:0] << (3'd4 - code_len));
          if (is_letter) begin
            step_d = ctrl.nxt;
          end else if (s_axis_tdata == mck_pkg::CHAR_SPACE) begin
            step_d = ctrl.jmp;
          end else begin
            step_d = mck_pkg::STEP_GAP;
          end
        end
      end
      mck_pkg::COND_LAST_SYM: begin
        if (emit_go) begin
          cnt_d  = cnt_q - 3'd1;
          pat_d  = {pat_q[2:0], 1'b0};
          step_d = (cnt_q == 3'd1) ? ctrl.jmp : ctrl.nxt;
        end
      end
      mck_pkg::COND_ALWAYS: begin
        if (emit_go) begin
          step_d = ctrl.nxt;
        end
      end
      default: begin
        step_d = mck_pkg::STEP_IDLE;
      end
    endcase

    if (emit_go) begin
      valid_d = 1'b1;
      lit_d   = ctrl.lit;
      last_d  = ctrl.last;
      dur_d   = long_seg ? dur_three : dur_one;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= mck_pkg::STEP_IDLE;
      valid_q <= 1'b0;
      unit_q  <= mck_pkg::UNIT_RESET;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    pat_q  <= pat_d;
    lit_q  <= lit_d;
    last_q <= last_d;
    dur_q  <= dur_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, dur_q, lit_q};
  assign m_axis_tlast  = last_q;

  `MCK_ASSERT(a_sym_has_count, (step_q != mck_pkg::STEP_SYM) || (cnt_q != 3'd0), "symbol step with empty count")
  `MCK_ASSERT_IMP(a_lit_not_last, m_axis_tvalid && m_axis_tdata[0], !m_axis_tlast, "lit segment marked last")
  `MCK_ASSERT_IMP(a_dur_nonzero, m_axis_tvalid, m_axis_tdata[18:1] != 18'd0, "zero segment duration")

endmodule

FILE: verif/testbench.sv
// Testbench for morse_code_keyer_unit: drives characters and unit lengths, checks every
// LED segment against an in-bench Morse encoder. Depends on mck_pkg and the keyer RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic        led_on;
    logic [17:0] duration;
    logic        last;
  } segment_t;

  // Symbol count in bits [6:4], symbols in [3:0] with the first one highest, 1 = dash.
  localparam logic [7:0] LETTER_PATTERNS [26] = '{
    8'h21, 8'h48, 8'h4A, 8'h34, 8'h10, 8'h42, 8'h36, 8'h40, 8'h20, 8'h47,
    8'h35, 8'h44, 8'h23, 8'h22, 8'h37, 8'h46, 8'h4D, 8'h32, 8'h30, 8'h11,
    8'h31, 8'h41, 8'h33, 8'h49, 8'h4B, 8'h4C
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [0] led_on, [18:1] duration_ticks, [23:19] zero
  logic        m_axis_tlast;

  segment_t    segments_due [$];
  logic [15:0] unit_setting = mck_pkg::UNIT_RESET;
  bit          steady = 1'b0;
  int          mismatches = 0;
  int          chars_sent = 0;
  int          segments_seen = 0;
  int          unit_writes = 0;

  morse_code_keyer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic segment_t make_segment(input logic lit, input int unsigned ticks,
                                            input logic fin);
    segment_t s;
    s.led_on   = lit;
    s.duration = 18'(ticks);
    s.last     = fin;
    return s;
  endfunction

  // Queue the segments one character should produce under the current unit length.
  task automatic predict_segments(input logic [7:0] c);
    int unsigned u;
    int unsigned n;
    logic [7:0]  pat;
    if (unit_setting == 16'd0) begin
      u = 1;
    end else begin
      u = 32'(unit_setting);
    end
    if (c >= mck_pkg::CHAR_A && c <= mck_pkg::CHAR_Z) begin
      pat = LETTER_PATTERNS[int'(c - mck_pkg::CHAR_A)];
      n = 32'(pat[6:4]);
      for (int i = 0; i < n; i++) begin
        if (i != 0) segments_due.push_back(make_segment(1'b0, u, 1'b0));
        segments_due.push_back(make_segment(1'b1, pat[n-1-i] ? 3 * u : u, 1'b0));
      end
    end else if (c == mck_pkg::CHAR_SPACE) begin
      segments_due.push_back(make_segment(1'b0, u, 1'b0));
    end
    segments_due.push_back(make_segment(1'b0, 3 * u, 1'b1));
  endtask

  task automatic send_char(input logic [7:0] c);
    if (!steady && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_segments(c);
    chars_sent++;
  endtask

  task automatic wait_drained();
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the unit length only with the keyer idle.
  task automatic set_unit_ticks(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    unit_setting  = v;
    unit_writes++;
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(mck_pkg::CHAR_A, mck_pkg::CHAR_Z));
    if (r < 72) return mck_pkg::CHAR_SPACE;
    if (r < 80) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 84) return 8'h0A;
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: check each transaction, then pick the next ready.
  always @(posedge clk_i) begin
    segment_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      segments_seen++;
      if (segments_due.size() == 0) begin
        mismatches++;
        $display("%0t: segment expected none, actual led=%0b dur=%0d last=%0b", $time,
                 m_axis_tdata[0], m_axis_tdata[18:1], m_axis_tlast);
      end else begin
        want = segments_due.pop_front();
        if (m_axis_tdata[0] !== want.led_on) begin
          mismatches++;
          $display("%0t: led_on expected %0b actual %0b", $time, want.led_on,
                   m_axis_tdata[0]);
        end
        if (m_axis_tdata[18:1] !== want.duration) begin
          mismatches++;
          $display("%0t: duration expected %0d actual %0d", $time, want.duration,
                   m_axis_tdata[18:1]);
        end
        if (m_axis_tlast !== want.last) begin
          mismatches++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
        end
      end
    end
    m_axis_tready <= rst_ni && (steady || $urandom_range(99) >= 18);
  end

  // Letters of every length and several shapes, space, and characters that give only the gap.
  task automatic test_directed();
    logic [7:0] chars [17] = '{"e", "t", "a", "z", "q", "y", "h", "o", " ", "A", "Z",
                               "\n", 8'h00, 8'hFF, 8'h60, 8'h7B, 8'h1F};
    foreach (chars[i]) send_char(chars[i]);
  endtask

  // Random text under several unit lengths, including zero and both ends of the range.
  task automatic test_unit_sweep();
    logic [15:0] units [6] = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd21845, 16'd0};
    foreach (units[i]) begin
      if (i == 5) units[i] = 16'($urandom_range(3, 65534));
      set_unit_ticks(units[i]);
      repeat (55) send_char(pick_char());
    end
  endtask

  // Back-to-back input and output with no random idling from the bench.
  task automatic test_steady_stream();
    set_unit_ticks(16'($urandom_range(1, 65535)));
    steady = 1'b1;
    repeat (60) send_char(pick_char());
    steady = 1'b0;
  endtask

  // Short bursts, each drained completely before the next.
  task automatic test_drained_bursts();
    set_unit_ticks(mck_pkg::UNIT_RESET);
    repeat (8) begin
      repeat ($urandom_range(2, 6)) send_char(pick_char());
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_unit_sweep();
    test_steady_stream();
    test_drained_bursts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d characters, checked %0d LED segments over %0d unit length writes.",
             chars_sent, segments_seen, unit_writes);
    $display("Covered letters, space, unknown codes, zero and full-scale unit lengths.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/mck_pkg.sv
design/morse_code_keyer_unit.sv
verif/testbench.sv
